FILE: hdl/gwc_pkg.sv
// Shared types and codes for the greedy weak coloring block.
package gwc_pkg;

    // Widths of the transaction fields.
    localparam int NODE_FIELD_W  = 6;
    localparam int COUNT_FIELD_W = 7;

    // Operation codes carried in the kind field.
    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_PLACE = 2'd3
    } kind_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_NBR,
        ST_SCAN,
        ST_JOIN,
        ST_RESULT,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic clear_adj;
        logic clear_cls;
        logic rd_sel_b;
        logic adj_wr;
        logic adj_wr_b;
        logic nbr_load;
        logic scan_start;
        logic scan_en;
        logic join_cls;
        logic res_plain;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  a_ok;
        logic  b_ok;
        logic  scan_done;
    } stat_t;

endpackage

FILE: hdl/gwc_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module gwc_ctrl
    import gwc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                // The adjacency row of node_a is read here for edges and placements.
                case (stat.kind)
                    KIND_CLEAR:
                    begin
                        cmd.clear_adj = 1'b1;
                        cmd.clear_cls = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    KIND_EDGE:
                    begin
                        state_next = (stat.a_ok && stat.b_ok) ? ST_EDGE_A : ST_RESULT;
                    end
                    KIND_RUN:
                    begin
                        cmd.clear_cls = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    KIND_PLACE:
                    begin
                        state_next = stat.a_ok ? ST_NBR : ST_RESULT;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_EDGE_A:
            begin
                cmd.adj_wr   = 1'b1;
                cmd.rd_sel_b = 1'b1;
                state_next   = ST_EDGE_B;
            end
            ST_EDGE_B:
            begin
                cmd.adj_wr   = 1'b1;
                cmd.adj_wr_b = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_NBR:
            begin
                cmd.nbr_load   = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_JOIN;
                end
            end
            ST_JOIN:
            begin
                cmd.join_cls = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_RESULT:
            begin
                cmd.res_plain = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait for the output register to be free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid is set on load and dropped once the result transaction completes.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/gwc_dpath.sv
// Datapath: adjacency memory, class memories, class scan and result registers.
module gwc_dpath
    import gwc_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic [1:0]               kind,
    input  logic [NODE_FIELD_W-1:0]  node_a,
    input  logic [NODE_FIELD_W-1:0]  node_b,
    output logic [NODE_FIELD_W-1:0]  class_id,
    output logic                     opened_new,
    output logic [COUNT_FIELD_W-1:0] class_count,
    output logic [COUNT_FIELD_W-1:0] class_size
);

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    // Latched transaction fields.
    kind_t                   kind_reg;
    logic [NODE_FIELD_W-1:0] a_reg;
    logic [NODE_FIELD_W-1:0] b_reg;
    logic [NODE_W-1:0]       a_idx;
    logic [NODE_W-1:0]       b_idx;

    // Adjacency memory with one valid bit per row.
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] adj_ok_reg;
    logic [MAX_NODES-1:0] adj_rd_reg;
    logic                 adj_rd_ok_reg;
    logic [MAX_NODES-1:0] adj_row;
    logic [NODE_W-1:0]    adj_ra;
    logic [NODE_W-1:0]    adj_wa;
    logic [MAX_NODES-1:0] adj_wd;

    // Class membership and size memories.
    logic [MAX_NODES-1:0] cls_mem  [MAX_NODES];
    logic [CNT_W-1:0]     size_mem [MAX_NODES];
    logic [MAX_NODES-1:0] mem_rd_reg;
    logic [CNT_W-1:0]     size_rd_reg;
    logic [CNT_W-1:0]     open_reg;

    // Scan state.
    logic [MAX_NODES-1:0] nbr_reg;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 pend_reg;
    logic [NODE_W-1:0]    pend_idx_reg;
    logic                 found_reg;
    logic [NODE_W-1:0]    best_idx_reg;
    logic [CNT_W-1:0]     best_size_reg;
    logic [MAX_NODES-1:0] best_mem_reg;
    logic                 issue;
    logic                 better;

    // Join logic.
    logic [MAX_NODES-1:0] a_bit;
    logic                 can_open;
    logic                 cls_we;
    logic [NODE_W-1:0]    cls_wa;
    logic [MAX_NODES-1:0] cls_wd;
    logic [CNT_W-1:0]     size_wd;

    // Result registers.
    logic [NODE_W-1:0]        res_id_reg;
    logic                     res_new_reg;
    logic [CNT_W-1:0]         res_size_reg;
    logic [NODE_FIELD_W-1:0]  class_id_reg;
    logic                     opened_new_reg;
    logic [COUNT_FIELD_W-1:0] class_count_reg;
    logic [COUNT_FIELD_W-1:0] class_size_reg;

    assign a_idx = NODE_W'(a_reg);
    assign b_idx = NODE_W'(b_reg);
    assign a_bit = MAX_NODES'(1) << a_idx;

    // Status to the controller.
    assign stat.kind      = kind_reg;
    assign stat.a_ok      = int'(a_reg) < MAX_NODES;
    assign stat.b_ok      = int'(b_reg) < MAX_NODES;
    assign stat.scan_done = (rd_idx_reg >= open_reg) && !pend_reg;

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= kind_t'(kind);
            a_reg    <= node_a;
            b_reg    <= node_b;
        end
    end

    // Adjacency read and edge write addresses; a row that is not valid reads as zero.
    assign adj_ra  = cmd.rd_sel_b ? b_idx : a_idx;
    assign adj_row = adj_rd_ok_reg ? adj_rd_reg : '0;
    assign adj_wa  = cmd.adj_wr_b ? b_idx : a_idx;
    assign adj_wd  = adj_row | (MAX_NODES'(1) << (cmd.adj_wr_b ? a_idx : b_idx));

    always_ff @(posedge clk)
    begin
        if (cmd.adj_wr)
        begin
            adj_mem[adj_wa] <= adj_wd;
        end
        adj_rd_reg    <= adj_mem[adj_ra];
        adj_rd_ok_reg <= adj_ok_reg[adj_ra];
    end

    // Row valid bits, cleared together when the graph is cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_ok_reg <= '0;
        end
        else if (cmd.clear_adj)
        begin
            adj_ok_reg <= '0;
        end
        else if (cmd.adj_wr)
        begin
            adj_ok_reg[adj_wa] <= 1'b1;
        end
    end

    // Scan issues one class read per cycle and evaluates it in the next cycle.
    assign issue  = cmd.scan_en && (rd_idx_reg < open_reg);
    assign better = pend_reg && (|(nbr_reg & ~mem_rd_reg))
                    && (!found_reg || (size_rd_reg < best_size_reg));

    // Join: grow the best class, or open a new class at the fill count if there is room.
    assign can_open = open_reg < CNT_W'(MAX_NODES);
    assign cls_we   = cmd.join_cls && (found_reg || can_open);
    assign cls_wa   = found_reg ? best_idx_reg : open_reg[NODE_W-1:0];
    assign cls_wd   = found_reg ? (best_mem_reg | a_bit) : a_bit;
    assign size_wd  = found_reg
                      ? (best_size_reg + CNT_W'(!best_mem_reg[a_idx]))
                      : CNT_W'(1);

    // Class memories; entries at or above the fill count may be read but are never used by the scan.
    always_ff @(posedge clk)
    begin
        if (cls_we)
        begin
            cls_mem[cls_wa]  <= cls_wd;
            size_mem[cls_wa] <= size_wd;
        end
        mem_rd_reg  <= cls_mem[rd_idx_reg[NODE_W-1:0]];
        size_rd_reg <= size_mem[rd_idx_reg[NODE_W-1:0]];
    end

    // Scan control and class fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_cls)
            begin
                open_reg <= '0;
            end
            else if (cmd.join_cls && !found_reg && can_open)
            begin
                open_reg <= open_reg + CNT_W'(1);
            end

            if (cmd.scan_start)
            begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Scan payload: neighbor row and best class so far.
    always_ff @(posedge clk)
    begin
        if (cmd.nbr_load)
        begin
            nbr_reg <= adj_row;
        end
        if (cmd.scan_en)
        begin
            pend_idx_reg <= rd_idx_reg[NODE_W-1:0];
            if (better)
            begin
                best_idx_reg  <= pend_idx_reg;
                best_size_reg <= size_rd_reg;
                best_mem_reg  <= mem_rd_reg;
            end
        end
    end

    // Result of the transaction, then the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.join_cls)
        begin
            res_id_reg   <= cls_we ? cls_wa : '0;
            res_new_reg  <= !found_reg && can_open;
            res_size_reg <= cls_we ? size_wd : '0;
        end
        else if (cmd.res_plain)
        begin
            res_id_reg   <= '0;
            res_new_reg  <= 1'b0;
            res_size_reg <= '0;
        end
        if (cmd.out_load)
        begin
            class_id_reg    <= NODE_FIELD_W'(res_id_reg);
            opened_new_reg  <= res_new_reg;
            class_count_reg <= COUNT_FIELD_W'(open_reg);
            class_size_reg  <= COUNT_FIELD_W'(res_size_reg);
        end
    end

    assign class_id    = class_id_reg;
    assign opened_new  = opened_new_reg;
    assign class_count = class_count_reg;
    assign class_size  = class_size_reg;

endmodule

FILE: hdl/greedy_weak_coloring.sv
// Greedy weak coloring: a placement passes through decode, neighbor load, a scan of the open
// classes, join and finish; the scan reads one class per cycle.
// Clear, new run and out-of-range items pass decode, result and finish; an edge first writes both rows.
// One transaction is in work at a time; the next is accepted in the cycle after the result is
// loaded, while that result may still wait in the output register.
// Reset (rst_n, asynchronous) empties the graph and all classes at once; no clearing pass.
module greedy_weak_coloring
    import gwc_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic [NODE_FIELD_W-1:0]  node_a,
    input  logic [NODE_FIELD_W-1:0]  node_b,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [NODE_FIELD_W-1:0]  class_id,
    output logic                     opened_new,
    output logic [COUNT_FIELD_W-1:0] class_count,
    output logic [COUNT_FIELD_W-1:0] class_size
);

    cmd_t  cmd;
    stat_t stat;

    // Controller.
    gwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath.
    gwc_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .node_a      (node_a),
        .node_b      (node_b),
        .class_id    (class_id),
        .opened_new  (opened_new),
        .class_count (class_count),
        .class_size  (class_size)
    );

    // Only one transaction is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a transaction is in work");

    // A newly opened class holds exactly the placed node.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && opened_new |-> class_size == COUNT_FIELD_W'(1))
        else $error("new class does not hold exactly one node");

    // A newly opened class is the last one created.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && opened_new |-> class_id == NODE_FIELD_W'(class_count - COUNT_FIELD_W'(1)))
        else $error("new class index does not match the class count");

endmodule
